/* hdl/boxavg_pkg.sv */
`timescale 1ns / 1ps

package boxavg_pkg;

  // Defaults for the top level parameters
  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_FACTOR = 16;

  // Tallest source image, in rows
  localparam int HEIGHT_LIMIT = 1024;

  // Field and register widths
  localparam int FACTOR_W = 5;
  localparam int DIM_W    = 11;
  localparam int PIX_W    = 8;
  localparam int SUM_W    = 16;
  // Position plus up to two blocks
  localparam int POS_W    = DIM_W + 1;
  localparam int SQ_W     = 2 * FACTOR_W;
  localparam int RECIP_W  = 15;

  // APB port
  localparam int APB_ADDR_W = 4;
  localparam int APB_DATA_W = 32;

  typedef enum logic [1:0] {
    REG_FACTOR = 2'd0,
    REG_WIDTH  = 2'd1,
    REG_HEIGHT = 2'd2
  } reg_idx_t;

  // Effective (clamped) configuration
  typedef struct packed {
    logic [FACTOR_W-1:0] factor;
    logic [DIM_W-1:0]    width;
    logic [DIM_W-1:0]    height;
  } cfg_t;

  // Completed block handed to the divider
  typedef struct packed {
    logic [SUM_W-1:0] sum;
    logic             last;
  } blk_t;

  // floor(65536 / (f*f)) for f = 0..31; f below 2 never used
  localparam logic [RECIP_W-1:0] RECIP_TAB [32] = '{
    15'd0,     15'd0,     15'd16384, 15'd7281,  15'd4096,  15'd2621,  15'd1820,  15'd1337,
    15'd1024,  15'd809,   15'd655,   15'd541,   15'd455,   15'd387,   15'd334,   15'd291,
    15'd256,   15'd226,   15'd202,   15'd181,   15'd163,   15'd148,   15'd135,   15'd123,
    15'd113,   15'd104,   15'd96,    15'd89,    15'd83,    15'd77,    15'd72,    15'd68
  };

endpackage

/* hdl/boxavg_cfg.sv */
`timescale 1ns / 1ps

module boxavg_cfg import boxavg_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_FACTOR = DEF_MAX_FACTOR
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  output cfg_t                  cfg,
  output logic                  restart
);

  logic [FACTOR_W-1:0] factor_reg;
  logic [DIM_W-1:0]    width_reg;
  logic [DIM_W-1:0]    height_reg;
  reg_idx_t            reg_idx;
  logic                wr;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[3:2]);
  assign wr      = psel && penable && pwrite;

  // any write to a known register restarts the frame
  always_comb begin
    restart = wr && (reg_idx inside {REG_FACTOR, REG_WIDTH, REG_HEIGHT});
  end

  // register file
  always_ff @(posedge clk) begin
    if (rst) begin
      factor_reg <= FACTOR_W'(2);
      width_reg  <= DIM_W'(64);
      height_reg <= DIM_W'(64);
    end else if (wr) begin
      case (reg_idx)
        REG_FACTOR: factor_reg <= pwdata[FACTOR_W-1:0];
        REG_WIDTH:  width_reg  <= pwdata[DIM_W-1:0];
        REG_HEIGHT: height_reg <= pwdata[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  // read back
  always_comb begin
    case (reg_idx)
      REG_FACTOR: prdata = APB_DATA_W'(factor_reg);
      REG_WIDTH:  prdata = APB_DATA_W'(width_reg);
      REG_HEIGHT: prdata = APB_DATA_W'(height_reg);
      default:    prdata = '0;
    endcase
  end

  // clamp to the supported ranges
  always_comb begin
    if (factor_reg < FACTOR_W'(2))       cfg.factor = FACTOR_W'(2);
    else if (int'(factor_reg) > MAX_FACTOR) cfg.factor = FACTOR_W'(MAX_FACTOR);
    else                                 cfg.factor = factor_reg;

    if (width_reg == '0)                 cfg.width = DIM_W'(1);
    else if (int'(width_reg) > MAX_WIDTH) cfg.width = DIM_W'(MAX_WIDTH);
    else                                 cfg.width = width_reg;

    if (height_reg == '0)                cfg.height = DIM_W'(1);
    else if (int'(height_reg) > HEIGHT_LIMIT) cfg.height = DIM_W'(HEIGHT_LIMIT);
    else                                 cfg.height = height_reg;
  end

endmodule

/* hdl/boxavg_accum.sv */
`timescale 1ns / 1ps

module boxavg_accum import boxavg_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_FACTOR = DEF_MAX_FACTOR
) (
  input  logic             clk,
  input  logic             rst,
  input  cfg_t             cfg,
  input  logic             restart,
  input  logic             pix_valid,
  output logic             pix_ready,
  input  logic [PIX_W-1:0] pixel,
  output logic             blk_valid,
  output blk_t             blk,
  input  logic             blk_ready
);

  localparam int DEPTH  = MAX_WIDTH / 2;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CB_W   = $clog2(MAX_FACTOR);

  // source position and block position
  logic [DIM_W-1:0]  src_col;
  logic [DIM_W-1:0]  src_row;
  logic [CB_W-1:0]   col_in_block;
  logic [CB_W-1:0]   row_in_block;
  logic [POS_W-1:0]  col_base;
  logic [POS_W-1:0]  row_base;
  logic [ADDR_W-1:0] tx;
  logic [SUM_W-1:0]  seg;

  // per-column partial block sums
  logic [SUM_W-1:0]  mem [DEPTH];
  logic [SUM_W-1:0]  rd_data;

  logic [POS_W-1:0]  f_pos;
  logic [POS_W-1:0]  col_end;
  logic [POS_W-1:0]  row_end;
  logic              col_fits;
  logic              row_fits;
  logic              last_col_blk;
  logic              last_row_blk;
  logic              in_region;
  logic              col_wrap;
  logic              row_wrap;
  logic              src_col_last;
  logic              src_row_last;
  logic [SUM_W-1:0]  seg_new;
  logic [SUM_W-1:0]  wr_data;
  logic              wr_en;
  logic              emit_now;
  logic              accept;

  // block bounds; a block counts only if it lies inside the image
  assign f_pos        = POS_W'(cfg.factor);
  assign col_end      = col_base + f_pos;
  assign row_end      = row_base + f_pos;
  assign col_fits     = col_end <= POS_W'(cfg.width);
  assign row_fits     = row_end <= POS_W'(cfg.height);
  assign last_col_blk = (col_end + f_pos) > POS_W'(cfg.width);
  assign last_row_blk = (row_end + f_pos) > POS_W'(cfg.height);
  assign in_region    = col_fits && row_fits;

  assign col_wrap     = 32'(col_in_block) + 32'd1 >= 32'(cfg.factor);
  assign row_wrap     = 32'(row_in_block) + 32'd1 >= 32'(cfg.factor);
  assign src_col_last = POS_W'(src_col) + POS_W'(1) >= POS_W'(cfg.width);
  assign src_row_last = POS_W'(src_row) + POS_W'(1) >= POS_W'(cfg.height);

  // read-modify-write of the column entry; first block row overwrites
  assign seg_new  = seg + SUM_W'(pixel);
  assign wr_data  = (row_in_block == '0) ? seg_new : rd_data + seg_new;
  assign emit_now = in_region && col_wrap && row_wrap;

  // stall only a pixel that completes a block while the divider is full
  assign pix_ready = !emit_now || blk_ready;
  assign accept    = pix_valid && pix_ready;
  assign wr_en     = accept && in_region && col_wrap;

  assign blk_valid = accept && emit_now;
  assign blk.sum   = wr_data;
  assign blk.last  = last_col_blk && last_row_blk;

  // store: read follows tx every cycle, tx is stable before its write
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[tx] <= wr_data;
    end
    rd_data <= mem[tx];
  end

  // raster counters
  always_ff @(posedge clk) begin
    if (rst || restart) begin
      src_col      <= '0;
      src_row      <= '0;
      col_in_block <= '0;
      row_in_block <= '0;
      col_base     <= '0;
      row_base     <= '0;
      tx           <= '0;
      seg          <= '0;
    end else if (accept) begin
      if (in_region) begin
        seg <= col_wrap ? '0 : seg_new;
      end
      if (src_col_last) begin
        src_col      <= '0;
        col_in_block <= '0;
        col_base     <= '0;
        tx           <= '0;
        seg          <= '0;
        if (src_row_last) begin
          src_row      <= '0;
          row_in_block <= '0;
          row_base     <= '0;
        end else begin
          src_row <= src_row + DIM_W'(1);
          if (row_wrap) begin
            row_in_block <= '0;
            row_base     <= row_base + f_pos;
          end else begin
            row_in_block <= row_in_block + CB_W'(1);
          end
        end
      end else begin
        src_col <= src_col + DIM_W'(1);
        if (col_wrap) begin
          col_in_block <= '0;
          col_base     <= col_base + f_pos;
          if (col_fits) begin
            tx <= tx + ADDR_W'(1);
          end
        end else begin
          col_in_block <= col_in_block + CB_W'(1);
        end
      end
    end
  end

  // two writes never land back to back, so the registered read is never stale
  a_wr_spacing: assert property (@(posedge clk) disable iff (rst)
    wr_en |=> !wr_en)
    else $error("store written on consecutive cycles");

  a_col_bound: assert property (@(posedge clk) disable iff (rst)
    32'(col_in_block) < 32'(cfg.factor))
    else $error("column in block out of range");

  a_row_bound: assert property (@(posedge clk) disable iff (rst)
    32'(row_in_block) < 32'(cfg.factor))
    else $error("row in block out of range");

endmodule

/* hdl/boxavg_div.sv */
`timescale 1ns / 1ps

module boxavg_div import boxavg_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic [FACTOR_W-1:0] factor,
  input  logic                blk_valid,
  input  blk_t                blk,
  output logic                blk_ready,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [PIX_W-1:0]    out_pixel,
  output logic                out_last
);

  localparam int PROD_W = SUM_W + RECIP_W;
  localparam int QD_W   = PIX_W + SQ_W;

  // stage 1: block sum with divisor constants
  logic                s1_valid;
  logic [SUM_W-1:0]    s1_sum;
  logic                s1_last;
  logic [RECIP_W-1:0]  s1_recip;
  logic [SQ_W-1:0]     s1_sq;

  // stage 2: reciprocal product
  logic                s2_valid;
  logic [PROD_W-1:0]   s2_prod;
  logic [SUM_W-1:0]    s2_sum;
  logic [SQ_W-1:0]     s2_sq;
  logic                s2_last;

  // output word
  logic                o_valid;
  logic [PIX_W-1:0]    o_pixel;
  logic                o_last;

  logic                advance;
  logic [PIX_W-1:0]    q_est;
  logic [QD_W-1:0]     qd;
  logic [QD_W-1:0]     rem;
  logic                fix;
  logic [PIX_W:0]      q_sum;

  // estimate is the quotient or one below; one compare corrects it
  assign q_est = s2_prod[SUM_W +: PIX_W];
  assign qd    = QD_W'(q_est) * QD_W'(s2_sq);
  assign rem   = QD_W'(s2_sum) - qd;
  assign fix   = rem >= QD_W'(s2_sq);
  assign q_sum = (PIX_W + 1)'(q_est) + (PIX_W + 1)'(fix);

  // the whole chain moves when the output word is free or taken
  assign advance   = !o_valid || out_ready;
  assign blk_ready = !s1_valid || advance;

  assign out_valid = o_valid;
  assign out_pixel = o_pixel;
  assign out_last  = o_last;

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      o_valid  <= 1'b0;
    end else begin
      if (advance) begin
        o_valid  <= s2_valid;
        s2_valid <= s1_valid;
      end
      if (blk_valid) begin
        s1_valid <= 1'b1;
      end else if (advance) begin
        s1_valid <= 1'b0;
      end
    end
  end

  // data path
  always_ff @(posedge clk) begin
    if (blk_valid) begin
      s1_sum   <= blk.sum;
      s1_last  <= blk.last;
      s1_recip <= RECIP_TAB[factor];
      s1_sq    <= SQ_W'(factor) * SQ_W'(factor);
    end
    if (advance) begin
      s2_prod <= PROD_W'(s1_sum) * PROD_W'(s1_recip);
      s2_sum  <= s1_sum;
      s2_sq   <= s1_sq;
      s2_last <= s1_last;
      o_pixel <= q_sum[PIX_W-1:0];
      o_last  <= s2_last;
    end
  end

  a_rem_range: assert property (@(posedge clk) disable iff (rst)
    s2_valid |-> (32'(rem) < 32'(s2_sq) * 32'd2))
    else $error("reciprocal estimate off by more than one");

  a_quot_range: assert property (@(posedge clk) disable iff (rst)
    s2_valid |-> !q_sum[PIX_W])
    else $error("quotient overflows a pixel");

  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !advance) |=> (s1_valid && $stable(s1_sum)))
    else $error("stalled block lost in stage one");

endmodule

/* hdl/box_average_downscaler_top.sv */
`timescale 1ns / 1ps

// Box-average downscaler: grey source pixels in, thumbnail pixels out.
// Slave stream (s_t*): one 8-bit source pixel per word, raster order.
// Master stream (m_t*): one thumbnail pixel per word; m_tlast marks the
// last thumbnail pixel of a frame. Each result is the truncated mean of a
// factor x factor block; right columns and bottom rows that do not fill a
// block are consumed and dropped.
// APB port: factor at 0x0, image_width at 0x4, image_height at 0x8. Any
// register write restarts the frame; write only while the block is idle.
// Throughput: one pixel per clock. Partial sums live in one entry per
// thumbnail column of a single-port store, read every cycle and written on
// the last pixel of each block row segment.
// Result path: a completed block passes through stage one (reciprocal lookup),
// stage two (multiply) and the output register (correction) before m_tvalid rises.
// Stall: while m_tready is low, up to three results queue in the divider;
// only a pixel that completes a block is then held off via s_tready.
// Reset: counters clear and registers return to factor 2, 64 x 64. The
// store needs no clearing pass: the first row of a block overwrites it.
module box_average_downscaler_top import boxavg_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_FACTOR = DEF_MAX_FACTOR
) (
  input  logic                  clk,
  input  logic                  rst,
  // APB
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  // source pixels
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [PIX_W-1:0]      s_tdata,   // [7:0] pixel
  // thumbnail pixels
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [PIX_W-1:0]      m_tdata,   // [7:0] thumb_pixel
  output logic                  m_tlast    // frame_end
);

  cfg_t cfg;
  logic restart;
  logic blk_valid;
  logic blk_ready;
  blk_t blk;

  boxavg_cfg #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_FACTOR (MAX_FACTOR)
  ) u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg),
    .restart (restart)
  );

  boxavg_accum #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_FACTOR (MAX_FACTOR)
  ) u_accum (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .restart   (restart),
    .pix_valid (s_tvalid),
    .pix_ready (s_tready),
    .pixel     (s_tdata),
    .blk_valid (blk_valid),
    .blk       (blk),
    .blk_ready (blk_ready)
  );

  boxavg_div u_div (
    .clk       (clk),
    .rst       (rst),
    .factor    (cfg.factor),
    .blk_valid (blk_valid),
    .blk       (blk),
    .blk_ready (blk_ready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_pixel (m_tdata),
    .out_last  (m_tlast)
  );

endmodule

/* verif/box_average_downscaler_top_test.sv */
`timescale 1ns / 1ps

module box_average_downscaler_top_test;
  import boxavg_pkg::*;

  localparam int STORE_DEPTH   = DEF_MAX_WIDTH / 2;
  localparam int DRAIN_CYCLES  = 8;         // output pipeline is 3 deep, plus margin
  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int RANDOM_PIXELS = 300;

  typedef struct packed {
    logic [PIX_W-1:0] thumb_pixel;
    logic             frame_end;
  } thumb_t;

  // DUT ports
  logic                  clk;
  logic                  rst      = 1'b1;
  logic                  psel     = 1'b0;
  logic                  penable  = 1'b0;
  logic                  pwrite   = 1'b0;
  logic [APB_ADDR_W-1:0] paddr    = '0;
  logic [APB_DATA_W-1:0] pwdata   = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [PIX_W-1:0]      s_tdata  = '0;   // [7:0] pixel
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [PIX_W-1:0]      m_tdata;         // [7:0] thumb_pixel
  logic                  m_tlast;         // frame_end

  // Predictor state: register copies, source position, partial sums
  logic [FACTOR_W-1:0] reg_factor = FACTOR_W'(2);
  logic [DIM_W-1:0]    reg_width  = DIM_W'(64);
  logic [DIM_W-1:0]    reg_height = DIM_W'(64);
  int unsigned         pos_col = 0, pos_row = 0, blk_col = 0, blk_row = 0;
  logic [SUM_W-1:0]    seg_sum = '0;
  logic [SUM_W-1:0]    col_sums [STORE_DEPTH] = '{default: '0};
  thumb_t              expected_thumbs [$];

  // Idling control and bookkeeping
  int unsigned src_gap_max = 12;
  int unsigned snk_gap_max = 12;
  int unsigned hold_request = 0;
  int unsigned hold_left = 0;
  int unsigned stall_left = 0;
  int unsigned pixels_sent = 0, pixels_used = 0, reg_writes = 0;
  int unsigned thumbs_checked = 0, frame_ends_seen = 0;
  int unsigned error_count = 0, cycle_count = 0;

  box_average_downscaler_top dut (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tlast (m_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Random pixel value
  function automatic logic [PIX_W-1:0] rand_pixel();
    return PIX_W'($urandom_range(0, 255));
  endfunction

  // Clamped geometry as the block sees it
  function automatic int unsigned eff_width();
    if (reg_width == '0) return 1;
    if (32'(reg_width) > DEF_MAX_WIDTH) return DEF_MAX_WIDTH;
    return 32'(reg_width);
  endfunction

  function automatic int unsigned eff_height();
    if (reg_height == '0) return 1;
    if (32'(reg_height) > HEIGHT_LIMIT) return HEIGHT_LIMIT;
    return 32'(reg_height);
  endfunction

  // Accumulate one source pixel; queue a thumbnail pixel when a block closes
  function automatic void downscale_pixel(input logic [PIX_W-1:0] px);
    int unsigned f, w, h, tw, th, tx;
    thumb_t      t;
    f = (reg_factor < FACTOR_W'(2)) ? 2 :
        (32'(reg_factor) > DEF_MAX_FACTOR) ? DEF_MAX_FACTOR : 32'(reg_factor);
    w = eff_width();
    h = eff_height();
    tw = w / f;
    th = h / f;
    if (pos_col < tw * f && pos_row < th * f) begin
      pixels_used++;
      seg_sum = seg_sum + SUM_W'(px);
      if (blk_col == f - 1) begin
        tx = (pos_col / f) % STORE_DEPTH;
        // first row of a block overwrites its column entry
        if (blk_row == 0) col_sums[tx] = seg_sum;
        else col_sums[tx] = col_sums[tx] + seg_sum;
        seg_sum = '0;
        if (blk_row == f - 1) begin
          t.thumb_pixel = PIX_W'(32'(col_sums[tx]) / (f * f));
          t.frame_end   = (pos_col / f == tw - 1) && (pos_row / f == th - 1);
          expected_thumbs.push_back(t);
        end
      end
    end
    // advance raster position, wrapping at the frame end
    if (pos_col + 1 >= w) begin
      pos_col = 0;
      blk_col = 0;
      seg_sum = '0;
      if (pos_row + 1 >= h) begin
        pos_row = 0;
        blk_row = 0;
      end else begin
        pos_row++;
        blk_row = (blk_row + 1 >= f) ? 0 : blk_row + 1;
      end
    end else begin
      pos_col++;
      blk_col = (blk_col + 1 >= f) ? 0 : blk_col + 1;
    end
  endfunction

  // Source side: random gap, then hold the word until accepted
  task automatic send_pixel(input logic [PIX_W-1:0] px);
    int unsigned gap;
    gap = $urandom_range(0, src_gap_max);
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= px;
    do @(posedge clk); while (!s_tready);
    pixels_sent++;
    downscale_pixel(px);
  endtask

  // APB write: setup cycle, then access cycle until pready
  task automatic write_reg(input reg_idx_t idx, input logic [APB_DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= APB_ADDR_W'(4 * idx);
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    case (idx)
      REG_FACTOR: reg_factor = value[FACTOR_W-1:0];
      REG_WIDTH:  reg_width  = value[DIM_W-1:0];
      REG_HEIGHT: reg_height = value[DIM_W-1:0];
      default: ;
    endcase
    // any write restarts the frame; column sums are kept
    pos_col = 0;
    pos_row = 0;
    blk_col = 0;
    blk_row = 0;
    seg_sum = '0;
    reg_writes++;
  endtask

  // Wait for every expected word, then let the pipeline empty
  task automatic settle();
    s_tvalid <= 1'b0;
    while (expected_thumbs.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic apply_settings(input int unsigned f, input int unsigned w,
                                input int unsigned h, input logic [2:0] mask);
    settle();
    if (mask[0]) write_reg(REG_FACTOR, f);
    if (mask[1]) write_reg(REG_WIDTH, w);
    if (mask[2]) write_reg(REG_HEIGHT, h);
  endtask

  // Reset values: factor 2 on a 64-wide image, two source rows
  task automatic test_reset_settings();
    repeat (2 * 64) send_pixel(rand_pixel());
  endtask

  // Saturated and truncating blocks, two frames back to back
  task automatic test_pixel_extremes();
    logic [PIX_W-1:0] frame_a [8] = '{8'd255, 8'd255, 8'd0, 8'd0, 8'd255, 8'd255, 8'd0, 8'd0};
    logic [PIX_W-1:0] frame_b [8] = '{8'd1, 8'd1, 8'd255, 8'd255, 8'd1, 8'd0, 8'd255, 8'd254};
    apply_settings(2, 4, 2, 3'b111);
    foreach (frame_a[i]) send_pixel(frame_a[i]);
    foreach (frame_b[i]) send_pixel(frame_b[i]);
  endtask

  // Right column and bottom row that do not fill a block must not leak in
  task automatic test_dropped_edges();
    apply_settings(2, 5, 3, 3'b111);
    for (int r = 0; r < 3; r++)
      for (int c = 0; c < 5; c++)
        send_pixel((c >= 4 || r >= 2) ? 8'd255 : PIX_W'(c * 10 + r * 3));
  endtask

  // Clamped registers and empty thumbnails
  task automatic test_out_of_range();
    apply_settings(1, 2, 2, 3'b111);          // factor below 2 acts as 2
    repeat (4) send_pixel(rand_pixel());
    apply_settings(2, 0, 3, 3'b111);          // zero width acts as 1: nothing out
    repeat (4) send_pixel(rand_pixel());
    apply_settings(2, 3, 0, 3'b111);          // zero height acts as 1: nothing out
    repeat (4) send_pixel(rand_pixel());
    apply_settings(31, 12, 12, 3'b111);       // factor clamps to 16, wider than image
    repeat (4) send_pixel(rand_pixel());
  endtask

  // Write in mid-frame, then a full frame from the top
  task automatic test_restart();
    apply_settings(2, 4, 4, 3'b111);
    repeat (6) send_pixel(rand_pixel());
    apply_settings(2, 4, 4, 3'b001);
    repeat (16) send_pixel(rand_pixel());
  endtask

  // Long receiver hold-off with the source streaming flat out
  task automatic test_backpressure();
    apply_settings(2, 8, 8, 3'b111);
    src_gap_max = 0;
    hold_request = 300;
    repeat (100) send_pixel(rand_pixel());
    src_gap_max = 12;
  endtask

  // Largest geometries and factors
  task automatic test_extreme_settings();
    apply_settings(2, 2047, 2, 3'b111);       // width clamps to 1024: row 1 starts there
    repeat (DEF_MAX_WIDTH + 2) send_pixel(rand_pixel());
    apply_settings(31, 16, 16, 3'b111);       // factor clamps to 16, full-scale 255s
    repeat (256) send_pixel(8'd255);
    apply_settings(2, 2, 2047, 3'b111);       // height far above the limit
    repeat (8) send_pixel(rand_pixel());
  endtask

  // Random settings, mostly whole frames with random content
  task automatic test_random_settings();
    int unsigned f, w, h, n, frame, style, start, r;
    logic [PIX_W-1:0] px;
    start = pixels_sent;
    while (pixels_sent - start < RANDOM_PIXELS) begin
      r = $urandom_range(0, 19);
      if (r < 14) f = $urandom_range(2, 5);
      else if (r < 17) f = $urandom_range(6, 16);
      else if (r < 19) f = $urandom_range(17, 31);
      else f = $urandom_range(0, 1);
      w = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 2047) : $urandom_range(0, 24);
      h = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 2047) : $urandom_range(0, 24);
      apply_settings(f, w, h, 3'($urandom_range(1, 7)));
      case ($urandom_range(0, 3))
        0: src_gap_max = 0;
        1: src_gap_max = 3;
        default: src_gap_max = 12;
      endcase
      case ($urandom_range(0, 3))
        0: snk_gap_max = 0;
        1: snk_gap_max = 3;
        default: snk_gap_max = 12;
      endcase
      frame = eff_width() * eff_height();
      if (frame <= 400) begin
        n = frame * $urandom_range(1, 3);
        if ($urandom_range(0, 3) == 0) n += $urandom_range(0, frame - 1);
      end else begin
        n = $urandom_range(100, 500);
      end
      if (n > RANDOM_PIXELS) n = RANDOM_PIXELS;
      style = $urandom_range(0, 3);
      repeat (n) begin
        case (style)
          1: px = ($urandom_range(0, 3) == 0) ? PIX_W'($urandom_range(200, 255)) : 8'd255;
          2: px = ($urandom_range(0, 3) == 0) ? PIX_W'($urandom_range(0, 15)) : 8'd0;
          default: px = rand_pixel();
        endcase
        send_pixel(px);
      end
    end
    src_gap_max = 12;
    snk_gap_max = 12;
  endtask

  // Sink side: random stall after each word, plus requested hold-offs
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_request != 0 || hold_left != 0) begin
      if (hold_request != 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      hold_left--;
      m_tready <= (hold_left == 0);
    end else if (stall_left != 0) begin
      stall_left--;
      m_tready <= (stall_left == 0);
    end else if (m_tready && m_tvalid) begin
      stall_left = $urandom_range(0, snk_gap_max);
      m_tready <= (stall_left == 0);
    end else begin
      m_tready <= 1'b1;
    end
  end

  // Compare each accepted thumbnail word with the oldest expectation
  always @(posedge clk) begin
    thumb_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_thumbs.size() == 0) begin
        $error("unexpected thumbnail word: thumb_pixel %0d frame_end %0b", m_tdata, m_tlast);
        error_count++;
      end else begin
        want = expected_thumbs.pop_front();
        thumbs_checked++;
        if (m_tlast) frame_ends_seen++;
        if (m_tdata !== want.thumb_pixel) begin
          $error("thumb_pixel: expected %0d, actual %0d", want.thumb_pixel, m_tdata);
          error_count++;
        end
        if (m_tlast !== want.frame_end) begin
          $error("frame_end: expected %0b, actual %0b", want.frame_end, m_tlast);
          error_count++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d words still expected",
               cycle_count, expected_thumbs.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    rst <= 1'b1;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_settings();
    test_pixel_extremes();
    test_dropped_edges();
    test_out_of_range();
    test_restart();
    test_backpressure();
    test_extreme_settings();
    test_random_settings();
    settle();
    $display("Run covered %0d source pixels (%0d inside thumbnail blocks)",
             pixels_sent, pixels_used);
    $display("over %0d register writes, and checked %0d thumbnail pixels (%0d frame ends).",
             reg_writes, thumbs_checked, frame_ends_seen);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

/* filelist.f */
hdl/boxavg_pkg.sv
hdl/boxavg_cfg.sv
hdl/boxavg_accum.sv
hdl/boxavg_div.sv
hdl/box_average_downscaler_top.sv
verif/box_average_downscaler_top_test.sv
